FILE: hw/rtl/qte_pkg.sv
// qte_pkg: shared widths, cordic arctangent table and step helpers for the
// quaternion to euler angle converter; no dependencies
`default_nettype none
package qte_pkg;
    localparam int COMPONENT_BITS = 16;
    localparam int ANGLE_BITS     = 16;
    localparam int FRAC_BITS      = COMPONENT_BITS - 1;
    localparam int TERM_BITS      = COMPONENT_BITS + 1;
    localparam int CORDIC_GUARD   = 58 - COMPONENT_BITS;
    localparam int CORDIC_STEPS   = 31;
    localparam int CW             = TERM_BITS + CORDIC_GUARD + 3;
    localparam int SQ_STEPS       = COMPONENT_BITS;
    localparam int SQ_BITS        = 2 * COMPONENT_BITS;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        cval_t       x;
        cval_t       y;
        logic [31:0] ang;
    } cvec_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] t;
        unique case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
            27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
            30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    // pre-rotation into the right half plane, zero vector kept at angle 0
    function automatic cvec_t cordic_start(input logic signed [TERM_BITS-1:0] yi,
                                           input logic signed [TERM_BITS-1:0] xi);
        cvec_t v;
        cval_t xs;
        cval_t ys;
        xs = cval_t'(xi) <<< CORDIC_GUARD;
        ys = cval_t'(yi) <<< CORDIC_GUARD;
        v.x = xs;
        v.y = ys;
        v.ang = 32'h0;
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                v.x = ys;
                v.y = -xs;
                v.ang = 32'h4000_0000;
            end
            else
            begin
                v.x = -ys;
                v.y = xs;
                v.ang = 32'hC000_0000;
            end
        end
        return v;
    endfunction

    function automatic cvec_t cordic_iter(input cvec_t v, input int i);
        cvec_t r;
        cval_t dx;
        cval_t dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.y >= 0)
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.ang = v.ang + atan_entry(i);
        end
        else
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.ang = v.ang - atan_entry(i);
        end
        return r;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] angle_round(input logic [31:0] a);
        logic [31:0] r;
        r = a;
        if (ANGLE_BITS < 32)
        begin
            r = a + (32'd1 << (31 - ANGLE_BITS));
        end
        return r[31 -: ANGLE_BITS];
    endfunction

    function automatic logic signed [TERM_BITS-1:0] sat_term(input logic signed [39:0] v);
        logic signed [39:0] lim;
        lim = 40'sd1 <<< COMPONENT_BITS;
        if (v > lim - 40'sd1)
            return TERM_BITS'(lim - 40'sd1);
        else if (v < -lim)
            return TERM_BITS'(-lim);
        else
            return TERM_BITS'(v);
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_angles_unit.sv
// quaternion to euler angle converter (zyx): q1.15 quaternion in, binary angles out
// depends on qte_pkg
//
// One request is taken per clock while the pipe advances, and results leave in
// the same order through a product stage, a sum and saturation stage, a
// term stage, sixteen restoring square root steps for the pitch cosine, thirty-one
// cordic vectoring steps shared in lockstep by the three atan2 lanes, and a rounding
// stage. The whole pipe advances only when the output register can move, so back
// pressure stalls it without loss. The block holds no state between requests.
`default_nettype none
module quaternion_to_euler_angles_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // w_component, x_component, y_component, z_component
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, pitch_clamped, zero fill
    output logic [55:0]      m_axis_tdata
);
    import qte_pkg::*;

    localparam int NSQ = SQ_STEPS;
    localparam int NC  = CORDIC_STEPS;
    localparam int CB  = COMPONENT_BITS;
    localparam int PB  = 2 * COMPONENT_BITS;

    typedef logic signed [CB-1:0]        comp_t;
    typedef logic signed [PB-1:0]        prod_t;
    typedef logic signed [TERM_BITS-1:0] term_t;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 1: products
    logic  v1_reg;
    prod_t wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    comp_t iw, ix, iy, iz;
    assign iw = s_axis_tdata[CB-1:0];
    assign ix = s_axis_tdata[2*CB-1:CB];
    assign iy = s_axis_tdata[3*CB-1:2*CB];
    assign iz = s_axis_tdata[4*CB-1:3*CB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= iw * ix;
            yz_reg <= iy * iz;
            xx_reg <= ix * ix;
            yy_reg <= iy * iy;
            wy_reg <= iw * iy;
            zx_reg <= iz * ix;
            wz_reg <= iw * iz;
            xy_reg <= ix * iy;
            zz_reg <= iz * iz;
        end
    end

    // stage 2: saturated terms
    logic v2_reg;
    term_t sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;
    logic signed [39:0] one_w;
    assign one_w = 40'sd1 <<< FRAC_BITS;

    function automatic logic signed [39:0] mq(input prod_t p);
        return 40'(p >>> FRAC_BITS);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg <= sat_term((mq(wx_reg) + mq(yz_reg)) <<< 1);
            cr_reg <= sat_term(one_w - ((mq(xx_reg) + mq(yy_reg)) <<< 1));
            sp_reg <= sat_term((mq(wy_reg) - mq(zx_reg)) <<< 1);
            sy_reg <= sat_term((mq(wz_reg) + mq(xy_reg)) <<< 1);
            cy_reg <= sat_term(one_w - ((mq(yy_reg) + mq(zz_reg)) <<< 1));
        end
    end

    // stage 3: clamp detect, sp squared and radicand
    logic v3_reg;
    term_t sr3_reg, cr3_reg, sp3_reg, sy3_reg, cy3_reg;
    logic clamp3_reg;
    logic [SQ_BITS-1:0] rad3_reg;
    logic signed [2*TERM_BITS-1:0] sp_sq;
    logic signed [2*TERM_BITS-1:0] one_sq;
    assign sp_sq = sp_reg * sp_reg;
    assign one_sq = (2*TERM_BITS)'(1) <<< (2*FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr3_reg <= sr_reg;
            cr3_reg <= cr_reg;
            sp3_reg <= sp_reg;
            sy3_reg <= sy_reg;
            cy3_reg <= cy_reg;
            clamp3_reg <= (sp_reg >= term_t'(one_w)) || (sp_reg <= -term_t'(one_w));
            rad3_reg <= SQ_BITS'(one_sq - sp_sq);
        end
    end

    // square root pipe, one result bit per stage
    logic sv_reg [NSQ+1];
    logic [SQ_BITS-1:0] rem_reg [NSQ+1];
    logic [SQ_BITS-1:0] res_reg [NSQ+1];
    term_t sr_q_reg [NSQ+1], cr_q_reg [NSQ+1], sp_q_reg [NSQ+1];
    term_t sy_q_reg [NSQ+1], cy_q_reg [NSQ+1];
    logic cl_q_reg [NSQ+1];

    always_comb
    begin
        rem_reg[0] = rad3_reg;
        res_reg[0] = '0;
        sv_reg[0] = v3_reg;
        sr_q_reg[0] = sr3_reg;
        cr_q_reg[0] = cr3_reg;
        sp_q_reg[0] = sp3_reg;
        sy_q_reg[0] = sy3_reg;
        cy_q_reg[0] = cy3_reg;
        cl_q_reg[0] = clamp3_reg;
    end

    genvar g;
    generate
        for (g = 0; g < NSQ; g++)
        begin : g_sq
            localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (SQ_BITS - 2 - 2*g);
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[g+1] <= 1'b0;
                else if (adv)
                    sv_reg[g+1] <= sv_reg[g];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (rem_reg[g] >= res_reg[g] + BIT)
                    begin
                        rem_reg[g+1] <= rem_reg[g] - (res_reg[g] + BIT);
                        res_reg[g+1] <= (res_reg[g] >> 1) + BIT;
                    end
                    else
                    begin
                        rem_reg[g+1] <= rem_reg[g];
                        res_reg[g+1] <= res_reg[g] >> 1;
                    end
                    sr_q_reg[g+1] <= sr_q_reg[g];
                    cr_q_reg[g+1] <= cr_q_reg[g];
                    sp_q_reg[g+1] <= sp_q_reg[g];
                    sy_q_reg[g+1] <= sy_q_reg[g];
                    cy_q_reg[g+1] <= cy_q_reg[g];
                    cl_q_reg[g+1] <= cl_q_reg[g];
                end
            end
        end
    endgenerate

    // cordic lanes: roll, pitch, yaw
    logic cv_reg [NC+1];
    cvec_t ra_reg [NC+1], pa_reg [NC+1], ya_reg [NC+1];
    logic ccl_reg [NC+1];
    logic cpos_reg [NC+1];
    term_t cosp;
    assign cosp = TERM_BITS'(res_reg[NSQ]);

    always_comb
    begin
        cv_reg[0] = sv_reg[NSQ];
        ra_reg[0] = cordic_start(sr_q_reg[NSQ], cr_q_reg[NSQ]);
        pa_reg[0] = cordic_start(sp_q_reg[NSQ], cosp);
        ya_reg[0] = cordic_start(sy_q_reg[NSQ], cy_q_reg[NSQ]);
        ccl_reg[0] = cl_q_reg[NSQ];
        cpos_reg[0] = sp_q_reg[NSQ] > 0;
    end

    generate
        for (g = 0; g < NC; g++)
        begin : g_cd
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[g+1] <= 1'b0;
                else if (adv)
                    cv_reg[g+1] <= cv_reg[g];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ra_reg[g+1] <= cordic_iter(ra_reg[g], g);
                    pa_reg[g+1] <= cordic_iter(pa_reg[g], g);
                    ya_reg[g+1] <= cordic_iter(ya_reg[g], g);
                    ccl_reg[g+1] <= ccl_reg[g];
                    cpos_reg[g+1] <= cpos_reg[g];
                end
            end
        end
    endgenerate

    // zero vector detection rides along: start gives x=y=0, iterations keep ang at sum of
    // table steps, so flag it separately
    logic rz_reg [NC+1];
    logic yz0_reg [NC+1];
    assign rz_reg[0] = (sr_q_reg[NSQ] == '0) && (cr_q_reg[NSQ] == '0);
    assign yz0_reg[0] = (sy_q_reg[NSQ] == '0) && (cy_q_reg[NSQ] == '0);
    generate
        for (g = 0; g < NC; g++)
        begin : g_zf
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rz_reg[g+1] <= rz_reg[g];
                    yz0_reg[g+1] <= yz0_reg[g];
                end
            end
        end
    endgenerate

    // output register
    logic out_v_reg;
    logic [ANGLE_BITS-1:0] roll_reg, pitch_reg, yaw_reg;
    logic clamp_reg;
    logic [ANGLE_BITS-1:0] qtr;
    assign qtr = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= cv_reg[NC];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg <= rz_reg[NC] ? '0 : angle_round(ra_reg[NC].ang);
            yaw_reg <= yz0_reg[NC] ? '0 : angle_round(ya_reg[NC].ang);
            clamp_reg <= ccl_reg[NC];
            if (ccl_reg[NC])
                pitch_reg <= cpos_reg[NC] ? qtr : -qtr;
            else
                pitch_reg <= angle_round(pa_reg[NC].ang);
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = 56'({clamp_reg, yaw_reg, pitch_reg, roll_reg});

    // pipe advances whenever output is free
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe stalled with empty output");
    // held result while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // clamped pitch is exactly a quarter turn
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && clamp_reg) |-> (pitch_reg == qtr || pitch_reg == -qtr))
        else $error("clamped pitch out of range");
endmodule
`default_nettype wire

FILE: test/tb.sv
// tb: self-checking bench for quaternion_to_euler_angles_unit, drives quaternions
// over the input stream and checks roll, pitch, yaw and the clamp flag of each result
// depends on qte_pkg and the converter rtl
`default_nettype none

class angle_scoreboard;
    logic [55:0] pending_angles[$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
    endfunction

    // floor shift of a signed value
    static function longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint mulq(longint a, longint b);
        return fshr(a * b, qte_pkg::FRAC_BITS);
    endfunction

    static function longint clamp_term(longint v);
        longint lim;
        lim = longint'(1) << qte_pkg::COMPONENT_BITS;
        if (v > lim - 1)
            return lim - 1;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    static function longint root_floor(longint n);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= n)
            r = (r + 1) * 2 <= n / (r + 1) ? r * 2 + 1 : r + 1;
        while (r * r > n)
            r = r - 1;
        return r;
    endfunction

    static function logic [31:0] vector_angle(longint ys, longint xs);
        logic [31:0] ang;
        longint xv;
        longint yv;
        longint tmp;
        longint dx;
        longint dy;
        logic [31:0] steps[31];
        steps = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                  32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
                  32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
                  32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
                  32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1};
        ang = 32'h0;
        if (xs == 0 && ys == 0)
            return ang;
        xv = xs <<< qte_pkg::CORDIC_GUARD;
        yv = ys <<< qte_pkg::CORDIC_GUARD;
        if (xv < 0)
        begin
            tmp = xv;
            if (yv >= 0)
            begin
                xv = yv;
                yv = -tmp;
                ang = 32'h4000_0000;
            end
            else
            begin
                xv = -yv;
                yv = tmp;
                ang = 32'hC000_0000;
            end
        end
        for (int i = 0; i < 31; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv = xv + dx;
                yv = yv - dy;
                ang = ang + steps[i];
            end
            else
            begin
                xv = xv - dx;
                yv = yv + dy;
                ang = ang - steps[i];
            end
        end
        return ang;
    endfunction

    static function logic [15:0] round_angle(logic [31:0] a);
        logic [31:0] r;
        r = a + (32'd1 << (31 - qte_pkg::ANGLE_BITS));
        return r[31:16];
    endfunction

    static function logic [55:0] euler_of(logic [63:0] q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint one;
        longint sr;
        longint cr;
        longint sp;
        longint sy;
        longint cy;
        logic [15:0] pitch;
        logic clamped;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        one = longint'(1) << qte_pkg::FRAC_BITS;
        sr = clamp_term(2 * (mulq(w, x) + mulq(y, z)));
        cr = clamp_term(one - 2 * (mulq(x, x) + mulq(y, y)));
        sp = clamp_term(2 * (mulq(w, y) - mulq(z, x)));
        sy = clamp_term(2 * (mulq(w, z) + mulq(x, y)));
        cy = clamp_term(one - 2 * (mulq(y, y) + mulq(z, z)));
        clamped = (sp >= one) || (sp <= -one);
        if (clamped)
            pitch = sp > 0 ? 16'sd16384 : -16'sd16384;
        else
            pitch = round_angle(vector_angle(sp, root_floor(one * one - sp * sp)));
        return {7'b0, clamped, round_angle(vector_angle(sy, cy)), pitch,
                round_angle(vector_angle(sr, cr))};
    endfunction

    function void note_request(logic [63:0] q);
        pending_angles.push_back(euler_of(q));
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        errors++;
    endtask

    task check_result(logic [55:0] got);
        logic [55:0] want;
        if (pending_angles.size() == 0)
        begin
            $display("mismatch: result with nothing pending");
            errors++;
            return;
        end
        want = pending_angles.pop_front();
        checked++;
        if (got[15:0] != want[15:0])
            report("roll", got[15:0], want[15:0]);
        if (got[31:16] != want[31:16])
            report("pitch", got[31:16], want[31:16]);
        if (got[47:32] != want[47:32])
            report("yaw", got[47:32], want[47:32]);
        if (got[48] != want[48])
            report("clamp", 16'(got[48]), 16'(want[48]));
        if (got[55:49] != 7'b0)
            report("fill", 16'(got[55:49]), 16'd0);
    endtask
endclass

module tb;
    localparam int LATENCY = 51;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    angle_scoreboard angles = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    longint cycles = 0;
    int directed_count = 0;

    quaternion_to_euler_angles_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                angles.check_result(m_axis_tdata);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one request, with random idle before it
    task send_quat(logic [63:0] q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= q;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        angles.note_request(q);
    endtask

    function automatic logic [15:0] near_unit_comp(int scale);
        int v;
        v = $urandom_range(scale);
        return $urandom_range(1) ? 16'(v) : 16'(-v);
    endfunction

    // roughly unit quaternion with random content
    function automatic logic [63:0] unit_quat();
        real a;
        real b;
        real c;
        real d;
        real n;
        a = real'($signed(16'($urandom))) ;
        b = real'($signed(16'($urandom)));
        c = real'($signed(16'($urandom)));
        d = real'($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            return 64'h0000_0000_0000_7fff;
        n = 32767.0 / n;
        return {16'($rtoi(d * n)), 16'($rtoi(c * n)), 16'($rtoi(b * n)), 16'($rtoi(a * n))};
    endfunction

    task drain();
        s_axis_tvalid <= 1'b0;
        while (angles.pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task random_phase(int n);
        logic [63:0] q;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0, 1: q = {$urandom, $urandom};
                2: q = {near_unit_comp(300), near_unit_comp(300),
                        near_unit_comp(300), near_unit_comp(300)};
                3:
                begin
                    // gimbal region: w = y or w = -y
                    q[15:0] = 16'($urandom_range(23170, 23200));
                    q[47:32] = $urandom_range(1) ? q[15:0] : -q[15:0];
                    q[31:16] = near_unit_comp(40);
                    q[63:48] = near_unit_comp(40);
                end
                default: q = unit_quat();
            endcase
            send_quat(q);
        end
    endtask

    logic [63:0] directed[$];

    initial
    begin
        directed = '{64'h0, 64'h0000_0000_0000_7fff, 64'h0000_0000_0000_8000,
                     64'h0000_0000_7fff_0000, 64'h0000_7fff_0000_0000,
                     64'h7fff_0000_0000_0000, 64'h8000_8000_8000_8000,
                     64'h7fff_7fff_7fff_7fff, 64'h0000_5a82_0000_5a82,
                     64'h0000_a57e_0000_5a82, 64'h5a82_0000_5a82_0000,
                     64'h4000_4000_4000_4000, 64'hc000_4000_c000_4000,
                     64'h0000_0000_0000_ffff, 64'h0000_0000_8000_0000,
                     64'h8000_0000_0000_0000, 64'h7fff_8000_7fff_8000,
                     64'hffff_ffff_ffff_ffff, 64'h0001_0000_0000_0000,
                     64'h0000_0000_0000_0001};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_quat(directed[i]);
        directed_count = directed.size();
        drain();

        random_phase(400);
        send_idle_pct = 62;
        random_phase(350);
        send_idle_pct = 0;
        stall_pct = 62;
        random_phase(350);
        send_idle_pct = 35;
        stall_pct = 35;
        random_phase(350);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 300;
        random_phase(250);
        drain();

        $display("covered %0d directed and %0d total quaternions across idle and stall mixes",
                 directed_count, angles.checked);
        if (angles.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
